### hw/rtl/mie_pkg.sv
// ---------------------------------------------------------------------------
// mie_pkg
// Shared types and instruction codes for the 8-bit microcontroller execute unit.
// ---------------------------------------------------------------------------
`default_nettype none

package mie_pkg;

    localparam logic [4:0] OP_MOVLW  = 5'd0;
    localparam logic [4:0] OP_ADDLW  = 5'd1;
    localparam logic [4:0] OP_MOVWF  = 5'd2;
    localparam logic [4:0] OP_CLRF   = 5'd3;
    localparam logic [4:0] OP_ANDLW  = 5'd4;
    localparam logic [4:0] OP_ADDWF  = 5'd5;
    localparam logic [4:0] OP_ANDWF  = 5'd6;
    localparam logic [4:0] OP_BCF    = 5'd7;
    localparam logic [4:0] OP_BSF    = 5'd8;
    localparam logic [4:0] OP_COMF   = 5'd9;
    localparam logic [4:0] OP_DECF   = 5'd10;
    localparam logic [4:0] OP_INCF   = 5'd11;
    localparam logic [4:0] OP_IORLW  = 5'd12;
    localparam logic [4:0] OP_IORWF  = 5'd13;
    localparam logic [4:0] OP_RLF    = 5'd14;
    localparam logic [4:0] OP_RRF    = 5'd15;
    localparam logic [4:0] OP_SUBLW  = 5'd16;
    localparam logic [4:0] OP_SUBWF  = 5'd17;
    localparam logic [4:0] OP_SWAPF  = 5'd18;
    localparam logic [4:0] OP_XORLW  = 5'd19;
    localparam logic [4:0] OP_XORWF  = 5'd20;
    localparam logic [4:0] OP_MOVF   = 5'd21;
    localparam logic [4:0] OP_GOTO   = 5'd22;
    localparam logic [4:0] OP_NOP    = 5'd23;
    localparam logic [4:0] OP_CLRW   = 5'd24;
    localparam logic [4:0] OP_DECFSZ = 5'd25;
    localparam logic [4:0] OP_INCFSZ = 5'd26;
    localparam logic [4:0] OP_BTFSC  = 5'd27;
    localparam logic [4:0] OP_BTFSS  = 5'd28;
    localparam logic [4:0] OP_CALL   = 5'd29;
    localparam logic [4:0] OP_RETURN = 5'd30;

    typedef struct packed {
        logic [4:0]  op;
        logic [6:0]  file_addr;
        logic        dest_file;
        logic [2:0]  bit_index;
        logic [7:0]  literal;
        logic [10:0] target_addr;
        logic [10:0] return_addr;
    } t_req;

    typedef struct packed {
        logic [7:0]  w_value;
        logic        carry;
        logic        digit_carry;
        logic        zero;
        logic [7:0]  result_value;
        logic        skip_next;
        logic        jump_taken;
        logic [10:0] jump_target;
    } t_rsp;

    typedef struct packed {
        logic c;
        logic dc;
        logic z;
    } t_flags;

    typedef struct packed {
        logic [7:0] res;
        t_flags     flags;
        logic       skip;
        logic       wr_w;
        logic       wr_f;
        logic       dest;
    } t_alu;

endpackage

`default_nettype wire

### hw/rtl/mcu_instruction_execute.sv
// ---------------------------------------------------------------------------
// mcu_instruction_execute
// Execute unit for an 8-bit microcontroller subset: working register, flags,
// data memory and return stack, one decoded instruction per request.
// ---------------------------------------------------------------------------
// Usage:
//   requests enter on i_in_valid / o_in_ready with a decoded instruction in
//   i_in_req; one response per request leaves on o_out_valid / i_out_ready
//   carrying W, the flags, the computed byte, the skip request and any jump.
//   the data memory read is registered with the request into the execute
//   stage, which computes and writes back into the output register.
//   without receiver stalls, throughput is one request per cycle; the data
//   memory read-modify-write with forwarding of the write in flight keeps it.
//   after reset W, flags, stack pointer and stack are zero and every data
//   byte reads as zero; per-byte valid flops make this take effect at once.
//   when the receiver stalls, the output register holds and the execute
//   stage fills; o_in_ready drops only once both are occupied.
// ---------------------------------------------------------------------------
`default_nettype none

module mcu_instruction_execute
    import mie_pkg::*;
#(
    parameter int DATA_WORDS  = 128,
    parameter int STACK_DEPTH = 8
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_req i_in_req,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output t_rsp      o_out_rsp
);

    localparam int AW  = $clog2(DATA_WORDS);
    localparam int SPW = $clog2(STACK_DEPTH);
    localparam logic [9:0]     DW10    = 10'(DATA_WORDS);
    localparam logic [SPW-1:0] SP_LAST = SPW'(STACK_DEPTH - 1);

    // pipeline control
    logic          in_fire;
    logic          s1_fire;
    logic [9:0]    addr_tmp;
    logic [AW-1:0] in_addr;

    // execute stage
    logic          r_s1_valid;
    t_req          r_s1_req;
    logic [AW-1:0] r_s1_addr;
    logic          r_fwd_hit;
    logic [7:0]    r_fwd_data;

    // architectural state
    logic [7:0]    r_w;
    t_flags        r_flags;
    logic          r_dvalid [DATA_WORDS];
    logic [10:0]   r_stack [STACK_DEPTH];
    logic [SPW-1:0] r_sp;

    // output register
    logic          r_out_valid;
    t_rsp          r_out_rsp;

    logic [7:0]     ram_q;
    logic [7:0]     f_byte;
    t_alu           alu;
    logic           ram_we;
    logic [7:0]     n_w;
    logic [SPW-1:0] n_sp;
    logic [SPW-1:0] sp_dec;
    logic           stack_we;
    t_rsp           n_rsp;

    // file address modulo data size
    always_comb begin
        addr_tmp = {3'b0, i_in_req.file_addr};
        for (int k = 2; k >= 0; k--) begin
            if (addr_tmp >= (DW10 << k)) begin
                addr_tmp = addr_tmp - (DW10 << k);
            end
        end
        in_addr = addr_tmp[AW-1:0];
    end

    assign s1_fire    = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s1_fire;
    assign in_fire    = i_in_valid && o_in_ready;

    mie_ram #(
        .WIDTH(8),
        .DEPTH(DATA_WORDS)
    ) u_data_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_s1_addr),
        .i_wdata(alu.res),
        .i_re   (in_fire),
        .i_raddr(in_addr),
        .o_rdata(ram_q)
    );

    assign f_byte = r_fwd_hit ? r_fwd_data : (r_dvalid[r_s1_addr] ? ram_q : 8'd0);

    mie_alu u_alu (
        .i_op   (r_s1_req.op),
        .i_f    (f_byte),
        .i_w    (r_w),
        .i_lit  (r_s1_req.literal),
        .i_bit  (r_s1_req.bit_index),
        .i_flags(r_flags),
        .o_alu  (alu)
    );

    assign sp_dec = (r_sp == '0) ? SP_LAST : r_sp - SPW'(1);

    always_comb begin
        ram_we   = s1_fire && (alu.wr_f || (alu.dest && r_s1_req.dest_file));
        n_w      = (alu.wr_w || (alu.dest && !r_s1_req.dest_file)) ? alu.res : r_w;
        n_sp     = r_sp;
        stack_we = 1'b0;

        n_rsp              = '0;
        n_rsp.w_value      = n_w;
        n_rsp.carry        = alu.flags.c;
        n_rsp.digit_carry  = alu.flags.dc;
        n_rsp.zero         = alu.flags.z;
        n_rsp.result_value = alu.res;
        n_rsp.skip_next    = alu.skip;

        case (r_s1_req.op)
            OP_GOTO: begin
                n_rsp.jump_taken  = 1'b1;
                n_rsp.jump_target = r_s1_req.target_addr;
            end
            OP_CALL: begin
                stack_we          = 1'b1;
                n_sp              = (r_sp == SP_LAST) ? '0 : r_sp + SPW'(1);
                n_rsp.jump_taken  = 1'b1;
                n_rsp.jump_target = r_s1_req.target_addr;
            end
            OP_RETURN: begin
                n_sp              = sp_dec;
                n_rsp.jump_taken  = 1'b1;
                n_rsp.jump_target = r_stack[sp_dec];
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_w         <= 8'd0;
            r_flags     <= '0;
            r_sp        <= '0;
            r_fwd_hit   <= 1'b0;
            for (int i = 0; i < DATA_WORDS; i++) begin
                r_dvalid[i] <= 1'b0;
            end
            for (int i = 0; i < STACK_DEPTH; i++) begin
                r_stack[i] <= 11'd0;
            end
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (in_fire) begin
                // write in flight to the same byte is not yet visible in the read
                r_fwd_hit <= ram_we && (in_addr == r_s1_addr);
            end
            if (s1_fire) begin
                r_out_valid <= 1'b1;
                r_w         <= n_w;
                r_flags     <= alu.flags;
                r_sp        <= n_sp;
                if (stack_we) begin
                    r_stack[r_sp] <= r_s1_req.return_addr;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (ram_we) begin
                r_dvalid[r_s1_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_s1_req   <= i_in_req;
            r_s1_addr  <= in_addr;
            r_fwd_data <= alu.res;
        end
        if (s1_fire) begin
            r_out_rsp <= n_rsp;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_rsp   = r_out_rsp;

endmodule

`default_nettype wire

### hw/rtl/mie_ram.sv
// ---------------------------------------------------------------------------
// mie_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

### hw/rtl/mie_alu.sv
// ---------------------------------------------------------------------------
// mie_alu
// Byte datapath: add, subtract, logic, rotate, bit and skip decisions.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_alu
    import mie_pkg::*;
(
    input  wire logic [4:0] i_op,
    input  wire logic [7:0] i_f,
    input  wire logic [7:0] i_w,
    input  wire logic [7:0] i_lit,
    input  wire logic [2:0] i_bit,
    input  wire t_flags     i_flags,
    output t_alu            o_alu
);

    logic [7:0] add_b;
    logic [8:0] add_sum;
    logic [4:0] add_nib;
    logic [7:0] sub_a;
    logic [7:0] sub_diff;
    logic       sub_c;
    logic       sub_dc;
    logic [7:0] mask;
    logic [7:0] f_dec;
    logic [7:0] f_inc;

    always_comb begin
        add_b    = (i_op == OP_ADDLW) ? i_lit : i_f;
        add_sum  = {1'b0, i_w} + {1'b0, add_b};
        add_nib  = {1'b0, i_w[3:0]} + {1'b0, add_b[3:0]};
        sub_a    = (i_op == OP_SUBLW) ? i_lit : i_f;
        sub_diff = sub_a - i_w;
        sub_c    = (i_w <= sub_a);
        sub_dc   = (i_w[3:0] <= sub_a[3:0]);
        mask     = 8'd1 << i_bit;
        f_dec    = i_f - 8'd1;
        f_inc    = i_f + 8'd1;

        o_alu       = '0;
        o_alu.flags = i_flags;

        case (i_op)
            OP_MOVLW: begin
                o_alu.res  = i_lit;
                o_alu.wr_w = 1'b1;
            end
            OP_ADDLW: begin
                o_alu.res      = add_sum[7:0];
                o_alu.flags.c  = add_sum[8];
                o_alu.flags.dc = add_nib[4];
                o_alu.flags.z  = (add_sum[7:0] == 8'd0);
                o_alu.wr_w     = 1'b1;
            end
            OP_MOVWF: begin
                o_alu.res  = i_w;
                o_alu.wr_f = 1'b1;
            end
            OP_CLRF: begin
                o_alu.res     = 8'd0;
                o_alu.flags.z = 1'b1;
                o_alu.wr_f    = 1'b1;
            end
            OP_ANDLW: begin
                o_alu.res     = i_w & i_lit;
                o_alu.flags.z = ((i_w & i_lit) == 8'd0);
                o_alu.wr_w    = 1'b1;
            end
            OP_ADDWF: begin
                o_alu.res      = add_sum[7:0];
                o_alu.flags.c  = add_sum[8];
                o_alu.flags.dc = add_nib[4];
                o_alu.flags.z  = (add_sum[7:0] == 8'd0);
                o_alu.dest     = 1'b1;
            end
            OP_ANDWF: begin
                o_alu.res     = i_w & i_f;
                o_alu.flags.z = ((i_w & i_f) == 8'd0);
                o_alu.dest    = 1'b1;
            end
            OP_BCF: begin
                o_alu.res  = i_f & ~mask;
                o_alu.wr_f = 1'b1;
            end
            OP_BSF: begin
                o_alu.res  = i_f | mask;
                o_alu.wr_f = 1'b1;
            end
            OP_COMF: begin
                o_alu.res     = ~i_f;
                o_alu.flags.z = (i_f == 8'hFF);
                o_alu.dest    = 1'b1;
            end
            OP_DECF: begin
                o_alu.res     = f_dec;
                o_alu.flags.z = (f_dec == 8'd0);
                o_alu.dest    = 1'b1;
            end
            OP_INCF: begin
                o_alu.res     = f_inc;
                o_alu.flags.z = (f_inc == 8'd0);
                o_alu.dest    = 1'b1;
            end
            OP_IORLW: begin
                o_alu.res     = i_w | i_lit;
                o_alu.flags.z = ((i_w | i_lit) == 8'd0);
                o_alu.wr_w    = 1'b1;
            end
            OP_IORWF: begin
                o_alu.res     = i_w | i_f;
                o_alu.flags.z = ((i_w | i_f) == 8'd0);
                o_alu.dest    = 1'b1;
            end
            OP_RLF: begin
                o_alu.res     = {i_f[6:0], i_flags.c};
                o_alu.flags.c = i_f[7];
                o_alu.dest    = 1'b1;
            end
            OP_RRF: begin
                o_alu.res     = {i_flags.c, i_f[7:1]};
                o_alu.flags.c = i_f[0];
                o_alu.dest    = 1'b1;
            end
            OP_SUBLW: begin
                o_alu.res      = sub_diff;
                o_alu.flags.c  = sub_c;
                o_alu.flags.dc = sub_dc;
                o_alu.flags.z  = (sub_diff == 8'd0);
                o_alu.wr_w     = 1'b1;
            end
            OP_SUBWF: begin
                o_alu.res      = sub_diff;
                o_alu.flags.c  = sub_c;
                o_alu.flags.dc = sub_dc;
                o_alu.flags.z  = (sub_diff == 8'd0);
                o_alu.dest     = 1'b1;
            end
            OP_SWAPF: begin
                o_alu.res  = {i_f[3:0], i_f[7:4]};
                o_alu.dest = 1'b1;
            end
            OP_XORLW: begin
                o_alu.res     = i_w ^ i_lit;
                o_alu.flags.z = ((i_w ^ i_lit) == 8'd0);
                o_alu.wr_w    = 1'b1;
            end
            OP_XORWF: begin
                o_alu.res     = i_w ^ i_f;
                o_alu.flags.z = ((i_w ^ i_f) == 8'd0);
                o_alu.dest    = 1'b1;
            end
            OP_MOVF: begin
                o_alu.res     = i_f;
                o_alu.flags.z = (i_f == 8'd0);
                o_alu.dest    = 1'b1;
            end
            OP_CLRW: begin
                o_alu.res     = 8'd0;
                o_alu.flags.z = 1'b1;
                o_alu.wr_w    = 1'b1;
            end
            OP_DECFSZ: begin
                o_alu.res  = f_dec;
                o_alu.skip = (f_dec == 8'd0);
                o_alu.dest = 1'b1;
            end
            OP_INCFSZ: begin
                o_alu.res  = f_inc;
                o_alu.skip = (f_inc == 8'd0);
                o_alu.dest = 1'b1;
            end
            OP_BTFSC: begin
                o_alu.res  = i_f;
                o_alu.skip = ((i_f & mask) == 8'd0);
            end
            OP_BTFSS: begin
                o_alu.res  = i_f;
                o_alu.skip = ((i_f & mask) != 8'd0);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

### hw/rtl/mie_checker.sv
// ---------------------------------------------------------------------------
// mie_checker
// Port-level checks for the execute unit, bound to the top level.
// ---------------------------------------------------------------------------
`default_nettype none

module mie_checker
    import mie_pkg::*;
(
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic i_in_valid,
    input wire logic o_in_ready,
    input wire t_req i_in_req,
    input wire logic o_out_valid,
    input wire logic i_out_ready,
    input wire t_rsp o_out_rsp
);

    // stalled response holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_out_rsp))
        else $error("response changed while stalled");

    a_no_out_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("response valid right after reset");

    a_target_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_rsp.jump_taken |-> o_out_rsp.jump_target == 11'd0)
        else $error("jump target set without a jump");

    a_skip_or_jump: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !(o_out_rsp.skip_next && o_out_rsp.jump_taken))
        else $error("skip and jump in one response");

    // an idle unit must take a request at once
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid && !$past(i_in_valid && o_in_ready) |-> o_in_ready)
        else $error("request refused while empty");

endmodule

bind mcu_instruction_execute mie_checker u_mie_checker (.*);

`default_nettype wire
